// ===== rtl/sde_pkg.sv =====
`timescale 1ns / 1ps
// sde_pkg: field widths and stream word layout for strict_dominance_elimination
// no dependencies

package sde_pkg;

  // configuration register
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd2;

  // fields of an input word
  localparam int PAYOFF_IN_W = 16;
  localparam int S_TDATA_W   = 2 * PAYOFF_IN_W;

  // fields of a result word
  localparam int RES_IDX_W    = 4;
  localparam int RES_CNT_W    = 5;
  localparam int M_TDATA_BITS = 2 * RES_IDX_W + 2 * PAYOFF_IN_W + 2 * RES_CNT_W;
  localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;
  localparam int M_PAD_W      = M_TDATA_W - M_TDATA_BITS;
  localparam int M_TUSER_W    = 1;

endpackage

// ===== rtl/strict_dominance_elimination.sv =====
`timescale 1ns / 1ps
// strict_dominance_elimination: matrix load, iterated elimination of strictly
// dominated strategies, result word; uses sde_pkg
// operation: cells load one per cycle while s_axis_tready is high; after the last
//   cell each turn walks the payoff memory, a read in ST_SCAN and a compare in
//   ST_CMP per compare, up to 4*n turns; a lowest-index search and result read follow
// throughput: one matrix at a time; the result word waits in an output register
// reset: size n = 2, load position zero; payoff memory is not cleared

module strict_dominance_elimination #(
  parameter int MAX_STRATEGIES = 16,
  parameter int PAYOFF_WIDTH   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sde_pkg::SIZE_W-1:0]     cfg_data_i,     // size_in_use
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sde_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // row_payoff, col_payoff
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_row, result_col, result_row_payoff, result_col_payoff, rows_left, cols_left
  output logic [sde_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic [sde_pkg::M_TUSER_W-1:0]  m_axis_tuser    // unique_res
);

  import sde_pkg::*;

  localparam int IDX_W  = $clog2(MAX_STRATEGIES);
  localparam int CNT_W  = $clog2(MAX_STRATEGIES + 1);
  localparam int DEPTH  = MAX_STRATEGIES * MAX_STRATEGIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 2 * PAYOFF_WIDTH;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_CMP,
    ST_LOW_R,
    ST_LOW_C,
    ST_READ,
    ST_OUT
  } state_e;

  state_e                    state_q;
  logic [SIZE_W-1:0]         size_q;
  logic [IDX_W-1:0]          ld_r_q, ld_c_q;
  logic [MAX_STRATEGIES-1:0] row_alive_q, col_alive_q;
  logic [CNT_W-1:0]          rows_left_q, cols_left_q;
  logic                      col_turn_q;
  logic [1:0]                idle_q;
  logic [CNT_W-1:0]          i_q, j_q, c_q;
  logic                      out_valid_q;
  logic [M_TDATA_W-1:0]      out_word_q;
  logic [M_TUSER_W-1:0]      out_user_q;

  logic [WORD_W-1:0]         pay_mem [DEPTH];
  logic [WORD_W-1:0]         rd_a_q, rd_b_q;

  logic [CNT_W-1:0]          n_sz;
  logic [IDX_W-1:0]          n_last;
  logic [IDX_W-1:0]          i_ix, j_ix, c_ix;
  logic [MAX_STRATEGIES-1:0] own_mask, opp_mask, one_hot_i;
  logic [CNT_W-1:0]          own_cnt;
  logic                      i_end, j_end, c_end, i_live, j_ok, c_live, scan_issue;
  logic                      wr_en, rd_en, more_turns, out_load;
  logic [ADDR_W-1:0]         wr_addr, addr_a, addr_b;
  logic signed [PAYOFF_WIDTH-1:0] rp_ext, cp_ext, pay_a, pay_b;
  logic [M_TDATA_W-1:0]      out_word;
  logic [M_TUSER_W-1:0]      out_user;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_STRATEGIES) + ADDR_W'(col));
  endfunction

  // effective size: zero acts as one, clamp to the array size
  always_comb begin
    if (size_q == '0) begin
      n_sz = CNT_W'(1);
    end else if (int'(size_q) > MAX_STRATEGIES) begin
      n_sz = CNT_W'(MAX_STRATEGIES);
    end else begin
      n_sz = CNT_W'(size_q);
    end
  end

  assign n_last = IDX_W'(n_sz - CNT_W'(1));

  assign i_ix = i_q[IDX_W-1:0];
  assign j_ix = j_q[IDX_W-1:0];
  assign c_ix = c_q[IDX_W-1:0];

  assign own_mask  = col_turn_q ? col_alive_q : row_alive_q;
  assign opp_mask  = col_turn_q ? row_alive_q : col_alive_q;
  assign own_cnt   = col_turn_q ? cols_left_q : rows_left_q;
  assign one_hot_i = {{(MAX_STRATEGIES-1){1'b0}}, 1'b1} << i_ix;

  assign i_end  = (i_q == n_sz);
  assign j_end  = (j_q == n_sz);
  assign c_end  = (c_q == n_sz);
  assign i_live = own_mask[i_ix];
  assign j_ok   = (j_q != i_q) && own_mask[j_ix];
  assign c_live = opp_mask[c_ix];
  assign scan_issue = (state_q == ST_SCAN) && !i_end && i_live && !j_end && j_ok &&
                      !c_end && c_live;

  assign more_turns = ((rows_left_q > CNT_W'(1)) || (cols_left_q > CNT_W'(1))) &&
                      (idle_q < 2'd2);

  assign rp_ext = PAYOFF_WIDTH'($signed(s_axis_tdata[PAYOFF_IN_W-1:0]));
  assign cp_ext = PAYOFF_WIDTH'($signed(s_axis_tdata[2*PAYOFF_IN_W-1:PAYOFF_IN_W]));

  assign wr_en   = s_axis_tvalid && s_axis_tready;
  assign wr_addr = cell_addr(ld_r_q, ld_c_q);
  assign rd_en   = scan_issue || (state_q == ST_READ);

  // own strategies i and j against opposing strategy c, per player; result cell in ST_READ
  always_comb begin
    if (state_q == ST_READ) begin
      addr_a = cell_addr(i_ix, j_ix);
    end else if (col_turn_q) begin
      addr_a = cell_addr(c_ix, i_ix);
    end else begin
      addr_a = cell_addr(i_ix, c_ix);
    end
    if (col_turn_q) begin
      addr_b = cell_addr(c_ix, j_ix);
    end else begin
      addr_b = cell_addr(j_ix, c_ix);
    end
  end

  // payoff memory: row payoff low, column payoff high
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pay_mem[wr_addr] <= {cp_ext, rp_ext};
    end
    if (rd_en) begin
      rd_a_q <= pay_mem[addr_a];
      rd_b_q <= pay_mem[addr_b];
    end
  end

  assign pay_a = col_turn_q ? $signed(rd_a_q[WORD_W-1:PAYOFF_WIDTH])
                            : $signed(rd_a_q[PAYOFF_WIDTH-1:0]);
  assign pay_b = col_turn_q ? $signed(rd_b_q[WORD_W-1:PAYOFF_WIDTH])
                            : $signed(rd_b_q[PAYOFF_WIDTH-1:0]);

  assign out_word = {
    {M_PAD_W{1'b0}},
    RES_CNT_W'(cols_left_q),
    RES_CNT_W'(rows_left_q),
    PAYOFF_IN_W'($signed(rd_a_q[WORD_W-1:PAYOFF_WIDTH])),
    PAYOFF_IN_W'($signed(rd_a_q[PAYOFF_WIDTH-1:0])),
    RES_IDX_W'(j_q),
    RES_IDX_W'(i_q)
  };
  assign out_user = M_TUSER_W'((rows_left_q == CNT_W'(1)) && (cols_left_q == CNT_W'(1)));

  // result word moves to the output register once that is free
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      size_q      <= SIZE_RESET;
      ld_r_q      <= '0;
      ld_c_q      <= '0;
      row_alive_q <= '1;
      col_alive_q <= '1;
      rows_left_q <= '0;
      cols_left_q <= '0;
      col_turn_q  <= 1'b0;
      idle_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_word_q  <= out_word;
        out_user_q  <= out_user;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (cfg_valid_i) begin
            size_q <= cfg_data_i;
            ld_r_q <= '0;
            ld_c_q <= '0;
          end else if (wr_en) begin
            if (ld_c_q == n_last) begin
              ld_c_q <= '0;
              if (ld_r_q == n_last) begin
                ld_r_q      <= '0;
                row_alive_q <= '1;
                col_alive_q <= '1;
                rows_left_q <= n_sz;
                cols_left_q <= n_sz;
                col_turn_q  <= 1'b0;
                idle_q      <= '0;
                state_q     <= ST_CHECK;
              end else begin
                ld_r_q <= ld_r_q + IDX_W'(1);
              end
            end else begin
              ld_c_q <= ld_c_q + IDX_W'(1);
            end
          end
        end
        ST_CHECK: begin
          i_q <= '0;
          j_q <= '0;
          c_q <= '0;
          if (!more_turns) begin
            state_q <= ST_LOW_R;
          end else if (own_cnt < CNT_W'(2)) begin
            idle_q     <= idle_q + 2'd1;
            col_turn_q <= !col_turn_q;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (i_end) begin
            idle_q     <= idle_q + 2'd1;
            col_turn_q <= !col_turn_q;
            state_q    <= ST_CHECK;
          end else if (!i_live || j_end) begin
            i_q <= i_q + CNT_W'(1);
            j_q <= '0;
            c_q <= '0;
          end else if (!j_ok) begin
            j_q <= j_q + CNT_W'(1);
            c_q <= '0;
          end else if (c_end) begin
            // strategy i is beaten by j everywhere
            if (col_turn_q) begin
              col_alive_q <= col_alive_q & ~one_hot_i;
              cols_left_q <= cols_left_q - CNT_W'(1);
            end else begin
              row_alive_q <= row_alive_q & ~one_hot_i;
              rows_left_q <= rows_left_q - CNT_W'(1);
            end
            idle_q     <= '0;
            col_turn_q <= !col_turn_q;
            state_q    <= ST_CHECK;
          end else if (!c_live) begin
            c_q <= c_q + CNT_W'(1);
          end else begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (pay_a >= pay_b) begin
            j_q <= j_q + CNT_W'(1);
            c_q <= '0;
          end else begin
            c_q <= c_q + CNT_W'(1);
          end
          state_q <= ST_SCAN;
        end
        ST_LOW_R: begin
          if (row_alive_q[i_ix]) begin
            j_q     <= '0;
            state_q <= ST_LOW_C;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        ST_LOW_C: begin
          if (col_alive_q[j_ix]) begin
            state_q <= ST_READ;
          end else begin
            j_q <= j_q + CNT_W'(1);
          end
        end
        ST_READ: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            row_alive_q <= '1;
            col_alive_q <= '1;
            col_turn_q  <= 1'b0;
            idle_q      <= '0;
            state_q     <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign cfg_ready_o   = (state_q == ST_LOAD);
  assign s_axis_tready = (state_q == ST_LOAD) && !cfg_valid_i;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_user_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_survivors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (rows_left_q != '0) && (cols_left_q != '0))
    else $error("survivor count dropped to zero");

  a_idle_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q != 2'd3)
    else $error("idle turn count overran");

  a_report_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> row_alive_q[i_ix] && col_alive_q[j_ix])
    else $error("reported cell is not a survivor");

  a_cmp_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_SCAN) && $past(rd_en))
    else $error("compare without a memory read");

endmodule
